@@ src/nrsd_pkg.sv @@
package nrsd_pkg;

  // Tile limits and field widths.
  localparam int unsigned POS_W      = 17;
  localparam int unsigned CAP_W      = 16;
  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned RUN_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NIB_W      = 4;

  localparam logic [POS_W-1:0] MAX_PIXELS = 17'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 2'd1;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Result kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT
  } state_t;

  // Operands and result of the shared position adder.
  typedef struct packed {
    logic [POS_W-1:0] base;
    logic [RUN_W-1:0] step;
    logic [POS_W-1:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [POS_W:0] sum;
    logic           over;
  } alu_res_t;

endpackage

@@ src/nrsd_alu.sv @@
module nrsd_alu
  import nrsd_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  // Advance the pixel position and flag a pass beyond the end of the tile.
  always_comb begin
    res.sum  = {1'b0, req.base} + {{(POS_W+1-RUN_W){1'b0}}, req.step};
    res.over = res.sum > {1'b0, req.limit};
  end

endmodule

@@ src/nrsd_top_placeholder.sv @@
module nrsd_out_reg
  import nrsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              kind,
  input  logic [ADDR_W-1:0] byte_address,
  input  logic [7:0]        byte_data,
  input  logic              merge_upper,
  input  logic              ok,
  input  logic              last,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [ADDR_W-1:0] out_byte_address,
  output logic [7:0]        out_byte_data,
  output logic              out_merge_upper,
  output logic              out_ok,
  output logic              out_last
);

  logic valid_r;

  // The slot may be refilled in the same cycle that its beat is taken.
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind         <= kind;
      out_byte_address <= byte_address;
      out_byte_data    <= byte_data;
      out_merge_upper  <= merge_upper;
      out_ok           <= ok;
      out_last         <= last;
    end
  end

endmodule

@@ src/nibble_rle_stream_decoder.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_cmd, in_code_byte
// out_      output     out_valid / out_ready  out_kind, out_byte_address, out_byte_data,
//                                             out_merge_upper, out_ok, out_last
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is accepted in the idle state, decoded, and then emitted one byte write at a time:
// a status item needs no emit step, and an encoded byte gives up to nine writes.
// The single position adder produces one write per cycle while the output slot is free.
// Reset is synchronous and active low; the tile starts out failed until a start beat passes.
// A stalled output holds the sequencer; configuration writes are taken at any time.
module nibble_rle_stream_decoder
  import nrsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_code_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [ADDR_W-1:0]    out_byte_address,
  output logic [7:0]           out_byte_data,
  output logic                 out_merge_upper,
  output logic                 out_ok,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [7:0]        code_r, code_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [RUN_W-1:0]  rem_r, rem_nxt;
  logic              failed_r, failed_nxt;
  logic [POS_W-1:0]  pixel_total_r;
  logic [CAP_W-1:0]  buffer_capacity_r;

  alu_req_t          alu_req;
  alu_res_t          alu_res;

  logic              slot_free;
  logic              load;
  logic              item_kind;
  logic [ADDR_W-1:0] item_addr;
  logic [7:0]        item_data;
  logic              item_merge;
  logic              item_ok;
  logic              item_last;

  logic [NIB_W-1:0]  pal;
  logic [RUN_W-1:0]  run;
  logic [RUN_W-1:0]  step;
  logic [RUN_W-1:0]  rem_left;
  logic [POS_W:0]    need_sum;
  logic              start_fail;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_total_r     <= '0;
      buffer_capacity_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIXEL_TOTAL:     pixel_total_r     <= cfg_data;
        REG_BUFFER_CAPACITY: buffer_capacity_r <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Decoded fields of the held code byte.
  assign pal  = code_r[NIB_W-1:0];
  assign run  = {1'b0, code_r[7:NIB_W]} + RUN_W'(1);

  // Each write covers one pixel when the position is odd or one pixel is left, else two.
  assign step     = (pos_r[0] || rem_r < RUN_W'(2)) ? RUN_W'(1) : RUN_W'(2);
  assign rem_left = rem_r - step;

  // Start check: the tile must be non-empty, at most MAX_PIXELS, and fit the buffer packed.
  assign need_sum   = {1'b0, pixel_total_r} + (POS_W+1)'(1);
  assign start_fail = (pixel_total_r == '0) || (pixel_total_r > MAX_PIXELS) ||
                      ({1'b0, buffer_capacity_r} < need_sum[POS_W:1]);

  // The shared adder checks the run in decode and advances the position in emit.
  always_comb begin
    alu_req.base  = pos_r;
    alu_req.limit = pixel_total_r;
    alu_req.step  = (state_r == S_EMIT) ? step : run;
  end

  nrsd_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Sequencer: next state and the item offered to the output register.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    code_nxt   = code_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    failed_nxt = failed_r;
    load       = 1'b0;
    item_kind  = KIND_STATUS;
    item_addr  = '0;
    item_data  = '0;
    item_merge = 1'b0;
    item_ok    = 1'b0;
    item_last  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          code_nxt  = in_code_byte;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (cmd_r == CMD_UNUSED) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_START: begin
              pos_nxt    = '0;
              failed_nxt = start_fail;
              load       = 1'b1;
              item_ok    = !start_fail;
            end
            CMD_FINISH: begin
              load    = 1'b1;
              item_ok = !failed_r && (pos_r == pixel_total_r);
            end
            default: begin
              if (failed_r) begin
                load = 1'b1;
              end else if (alu_res.over) begin
                failed_nxt = 1'b1;
                load       = 1'b1;
              end else begin
                rem_nxt   = run;
                state_nxt = S_EMIT;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          item_kind  = KIND_WRITE;
          item_addr  = pos_r[ADDR_W:1];
          item_ok    = 1'b1;
          item_last  = (rem_left == '0);
          item_merge = pos_r[0];
          if (pos_r[0]) begin
            item_data = {pal, {NIB_W{1'b0}}};
          end else if (step == RUN_W'(2)) begin
            item_data = {pal, pal};
          end else begin
            item_data = {{NIB_W{1'b0}}, pal};
          end
          pos_nxt = alu_res.sum[POS_W-1:0];
          rem_nxt = rem_left;
          if (rem_left == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      failed_r <= 1'b1;
      rem_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      failed_r <= failed_nxt;
      rem_r    <= rem_nxt;
    end
  end

  // Held command beat.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    code_r <= code_nxt;
  end

  nrsd_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .kind             (item_kind),
    .byte_address     (item_addr),
    .byte_data        (item_data),
    .merge_upper      (item_merge),
    .ok               (item_ok),
    .last             (item_last),
    .free             (slot_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte_address (out_byte_address),
    .out_byte_data    (out_byte_data),
    .out_merge_upper  (out_merge_upper),
    .out_ok           (out_ok),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // A status beat always closes its command.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_last)
    else $error("status beat without last");

  // Every write beat reports success.
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRITE |-> out_ok)
    else $error("write beat with ok low");

  // A merge writes only the upper nibble.
  a_merge_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_merge_upper |-> out_byte_data[NIB_W-1:0] == '0)
    else $error("merge beat carries lower nibble");

  // The emitter never runs with an empty run.
  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> rem_r != '0)
    else $error("emit state with no pixels left");

  // A beat is not taken while the previous one is still being worked.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");
`endif

endmodule

@@ tb/nibble_rle_stream_decoder_tb.sv @@
`timescale 1ns / 1ps

module nibble_rle_stream_decoder_tb;
  import nrsd_pkg::*;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] code;
  } cmd_beat_t;

  typedef struct {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              merge;
    logic              ok;
    logic              last;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_cmd = CMD_START;
  logic [7:0]           in_code_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_kind;
  logic [ADDR_W-1:0]    out_byte_address;
  logic [7:0]           out_byte_data;
  logic                 out_merge_upper;
  logic                 out_ok;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PIXEL_TOTAL;
  logic [POS_W-1:0]     cfg_data = '0;

  // Command beats waiting to be sent, and the result beats the decoder still owes.
  cmd_beat_t queued_cmds[$];
  result_t   writes_due[$];
  result_t   head_due;
  cmd_beat_t next_cmd;
  int        cmds_queued = 0;
  int        mismatches = 0;

  // Decoder state as the testbench sees it, including the register copies.
  logic [POS_W-1:0] pix_total = '0;
  logic [CAP_W-1:0] buf_capacity = '0;
  logic [POS_W-1:0] tile_pos = '0;
  logic             tile_failed = 1'b1;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_pattern = 16'hffff;
  logic [5:0]  pattern_age = '0;

  nibble_rle_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte_address (out_byte_address),
    .out_byte_data    (out_byte_data),
    .out_merge_upper  (out_merge_upper),
    .out_ok           (out_ok),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t make_result(logic kind, int unsigned addr, logic [7:0] data,
                                          logic merge, logic ok);
    result_t r;
    r.kind  = kind;
    r.addr  = addr[ADDR_W-1:0];
    r.data  = data;
    r.merge = merge;
    r.ok    = ok;
    r.last  = 1'b0;
    return r;
  endfunction

  // Work out the result beats of one accepted command and update the tile state.
  task automatic decode_command(input cmd_t cmd, input logic [7:0] code);
    int unsigned pos;
    int unsigned run;
    int unsigned need;
    logic [3:0]  pal;
    result_t     batch[$];
    case (cmd)
      CMD_START: begin
        need = (32'(pix_total) + 32'd1) >> 1;
        tile_pos = '0;
        tile_failed = (pix_total == '0) || (pix_total > MAX_PIXELS) ||
                      (32'(buf_capacity) < need);
        batch.push_back(make_result(KIND_STATUS, 0, 8'h00, 1'b0, !tile_failed));
      end
      CMD_FINISH: begin
        batch.push_back(make_result(KIND_STATUS, 0, 8'h00, 1'b0,
                                    !tile_failed && (tile_pos == pix_total)));
      end
      CMD_BYTE: begin
        run = 32'(code[7:4]) + 32'd1;
        pal = code[3:0];
        pos = 32'(tile_pos);
        if (tile_failed) begin
          batch.push_back(make_result(KIND_STATUS, 0, 8'h00, 1'b0, 1'b0));
        end else if (pos + run > 32'(pix_total)) begin
          // A run past the end of the tile fails it without writing anything.
          tile_failed = 1'b1;
          batch.push_back(make_result(KIND_STATUS, 0, 8'h00, 1'b0, 1'b0));
        end else begin
          // An odd position first merges into the upper nibble of its byte.
          if (pos[0]) begin
            batch.push_back(make_result(KIND_WRITE, pos >> 1, {pal, 4'h0}, 1'b1, 1'b1));
            pos++;
            run--;
          end
          while (run >= 2) begin
            batch.push_back(make_result(KIND_WRITE, pos >> 1, {pal, pal}, 1'b0, 1'b1));
            pos += 2;
            run -= 2;
          end
          if (run > 0) begin
            batch.push_back(make_result(KIND_WRITE, pos >> 1, {4'h0, pal}, 1'b0, 1'b1));
            pos++;
          end
          tile_pos = pos[POS_W-1:0];
        end
      end
      default: begin
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size()-1].last = 1'b1;
    end
    foreach (batch[i]) begin
      writes_due.push_back(batch[i]);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_command(cmd_t'(in_cmd), in_code_byte);
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_cmds.size() > 0) begin
          next_cmd = queued_cmds.pop_front();
          in_valid <= 1'b1;
          in_cmd <= next_cmd.cmd;
          in_code_byte <= next_cmd.code;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 7);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating ready pattern, replaced each time the pattern age counter wraps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (pattern_age == 6'd63) begin
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff :
                         (16'($urandom) | 16'h0101);
      end else begin
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      pattern_age <= pattern_age + 6'd1;
      out_ready <= ready_pattern[0];
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: every result beat is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (writes_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual kind %0d addr 0x%0h",
                 $time, out_kind, out_byte_address);
        mismatches++;
      end else begin
        head_due = writes_due.pop_front();
        compare_field("kind", 32'(head_due.kind), 32'(out_kind));
        compare_field("byte_address", 32'(head_due.addr), 32'(out_byte_address));
        compare_field("byte_data", 32'(head_due.data), 32'(out_byte_data));
        compare_field("merge_upper", 32'(head_due.merge), 32'(out_merge_upper));
        compare_field("ok", 32'(head_due.ok), 32'(out_ok));
        compare_field("last", 32'(head_due.last), 32'(out_last));
      end
    end
  end

  task automatic queue_cmd(input cmd_t cmd, input logic [7:0] code);
    cmd_beat_t b;
    b.cmd  = cmd;
    b.code = code;
    queued_cmds.push_back(b);
    cmds_queued++;
  endtask

  // Hold the sender back until every owed beat has arrived, then let the
  // decoder settle, since an ignored command leaves nothing to wait for.
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_cmds.size() != 0 || in_valid || writes_due.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_PIXEL_TOTAL) begin
      pix_total = value;
    end else if (idx == REG_BUFFER_CAPACITY) begin
      buf_capacity = value[CAP_W-1:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // A start, mostly well-formed runs with the odd stray or overflowing beat,
  // then a finish.
  task automatic queue_tile(input int unsigned total);
    int unsigned left;
    int unsigned run;
    int unsigned roll;
    int          nbytes;
    left = total;
    nbytes = 0;
    queue_cmd(CMD_START, 8'($urandom));
    while (left > 0 && nbytes < 12) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        queue_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom));
      end else if (roll == 1) begin
        queue_cmd(CMD_BYTE, 8'($urandom));
      end else begin
        run = $urandom_range(1, (left < 16) ? left : 16);
        queue_cmd(CMD_BYTE, {4'(run - 1), 4'($urandom)});
        left -= run;
      end
      nbytes++;
    end
    queue_cmd(CMD_FINISH, 8'($urandom));
  endtask

  initial begin
    #(40_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned total;
    int unsigned need;
    int unsigned cap;
    int          target;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset no tile has been started and the registers are zero.
    queue_cmd(CMD_BYTE, 8'h00);
    queue_cmd(CMD_FINISH, 8'h00);
    queue_cmd(CMD_START, 8'hff);
    queue_cmd(CMD_BYTE, 8'hff);
    queue_cmd(CMD_UNUSED, 8'haa);
    wait_drained();

    // Tile size over the maximum, then a buffer one byte short of the maximum tile.
    write_reg(REG_PIXEL_TOTAL, 17'd65537);
    write_reg(REG_BUFFER_CAPACITY, 17'd65535);
    queue_cmd(CMD_START, 8'h00);
    wait_drained();
    write_reg(REG_PIXEL_TOTAL, 17'd65536);
    write_reg(REG_BUFFER_CAPACITY, 17'd32767);
    queue_cmd(CMD_START, 8'h00);
    wait_drained();
    write_reg(REG_BUFFER_CAPACITY, 17'h18000);
    queue_cmd(CMD_START, 8'h00);
    queue_cmd(CMD_FINISH, 8'h00);
    wait_drained();

    // An odd tile: capacity one short, then exact, runs from odd and even positions.
    write_reg(REG_PIXEL_TOTAL, 17'd37);
    write_reg(REG_BUFFER_CAPACITY, 17'd18);
    queue_cmd(CMD_START, 8'h00);
    wait_drained();
    write_reg(REG_BUFFER_CAPACITY, 17'd19);
    queue_cmd(CMD_START, 8'h00);
    queue_cmd(CMD_BYTE, 8'h00);
    queue_cmd(CMD_BYTE, 8'hf5);
    queue_cmd(CMD_BYTE, 8'h1a);
    queue_cmd(CMD_BYTE, 8'h2c);
    queue_cmd(CMD_BYTE, 8'he3);
    queue_cmd(CMD_FINISH, 8'h00);
    queue_cmd(CMD_BYTE, 8'h07);
    queue_cmd(CMD_FINISH, 8'h00);
    queue_cmd(CMD_BYTE, 8'h31);
    queue_cmd(CMD_START, 8'h00);
    queue_cmd(CMD_FINISH, 8'h00);
    wait_drained();

    // The smallest tile.
    write_reg(REG_PIXEL_TOTAL, 17'd1);
    write_reg(REG_BUFFER_CAPACITY, 17'd1);
    queue_cmd(CMD_START, 8'h00);
    queue_cmd(CMD_BYTE, 8'h0f);
    queue_cmd(CMD_FINISH, 8'h00);
    wait_drained();

    // Fill a small tile exactly, then widen it mid-tile and carry on from its end.
    write_reg(REG_PIXEL_TOTAL, 17'd64);
    write_reg(REG_BUFFER_CAPACITY, 17'd32);
    queue_cmd(CMD_START, 8'h00);
    repeat (4) queue_cmd(CMD_BYTE, {4'hf, 4'($urandom)});
    wait_drained();
    write_reg(REG_PIXEL_TOTAL, 17'd100);
    write_reg(REG_BUFFER_CAPACITY, 17'd50);
    queue_cmd(CMD_BYTE, 8'h0c);
    repeat (4) queue_cmd(CMD_BYTE, {4'($urandom), 4'($urandom)});
    queue_cmd(CMD_FINISH, 8'h00);
    queue_cmd(CMD_START, 8'h00);
    wait_drained();

    // Random tiles over a spread of sizes and buffer capacities.
    repeat (5) begin
      case ($urandom_range(0, 15))
        0:       total = $urandom_range(65537, 131071);
        1:       total = 65536;
        2:       total = 0;
        3:       total = 1;
        default: total = $urandom_range(2, 48);
      endcase
      need = (total + 1) / 2;
      case ($urandom_range(0, 9))
        0:       cap = (need > 0) ? need - 1 : 0;
        1:       cap = 65535;
        default: cap = need + $urandom_range(0, 3);
      endcase
      if (cap > 65535) begin
        cap = 65535;
      end
      write_reg(REG_PIXEL_TOTAL, total[POS_W-1:0]);
      write_reg(REG_BUFFER_CAPACITY, {1'($urandom), cap[CAP_W-1:0]});
      target = cmds_queued + 19;
      while (cmds_queued < target) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          queue_tile(total);
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
